// ===== rtl/hse_pkg.sv =====
`default_nettype none
package hse_pkg;

  // Default width of the written-byte counter, and the widest it may be
  localparam int LENGTH_BITS_DEFAULT = 16;
  localparam int MAX_LEN_BITS = 32;

  // Job queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 4;

  // Characters that need escaping
  localparam logic [7:0] CHAR_LT   = 8'h3C;
  localparam logic [7:0] CHAR_GT   = 8'h3E;
  localparam logic [7:0] CHAR_QUOT = 8'h22;
  localparam logic [7:0] CHAR_APOS = 8'h27;
  localparam logic [7:0] CHAR_AMP  = 8'h26;

  // Escape sequences, left aligned in six byte places
  localparam logic [47:0] SEQ_LT   = {"&lt;", 16'h0000};
  localparam logic [47:0] SEQ_GT   = {"&gt;", 16'h0000};
  localparam logic [47:0] SEQ_QUOT = "&quot;";
  localparam logic [47:0] SEQ_APOS = "&#039;";
  localparam logic [47:0] SEQ_AMP  = {"&amp;", 8'h00};

  typedef enum logic [2:0] {
    CODE_LIT,
    CODE_LT,
    CODE_GT,
    CODE_QUOT,
    CODE_APOS,
    CODE_AMP
  } code_t;

  // One unit of work for the back end
  typedef struct packed {
    logic       has_bytes;
    code_t      code;
    logic [7:0] lit;
    logic       has_term;
    logic       term_store;
    logic       term_trunc;
  } job_t;

  function automatic code_t esc_code(input logic [7:0] c);
    code_t r;
    case (c)
      CHAR_LT:   r = CODE_LT;
      CHAR_GT:   r = CODE_GT;
      CHAR_QUOT: r = CODE_QUOT;
      CHAR_APOS: r = CODE_APOS;
      CHAR_AMP:  r = CODE_AMP;
      default:   r = CODE_LIT;
    endcase
    return r;
  endfunction

  // Number of output bytes a code expands to
  function automatic logic [2:0] esc_len(input code_t code);
    logic [2:0] r;
    case (code)
      CODE_LT:   r = 3'd4;
      CODE_GT:   r = 3'd4;
      CODE_QUOT: r = 3'd6;
      CODE_APOS: r = 3'd6;
      CODE_AMP:  r = 3'd5;
      default:   r = 3'd1;
    endcase
    return r;
  endfunction

  // Byte at place pos of the expansion
  function automatic logic [7:0] esc_char(input code_t code, input logic [2:0] pos,
                                          input logic [7:0] lit);
    logic [47:0] seq;
    logic [47:0] shifted;
    case (code)
      CODE_LT:   seq = SEQ_LT;
      CODE_GT:   seq = SEQ_GT;
      CODE_QUOT: seq = SEQ_QUOT;
      CODE_APOS: seq = SEQ_APOS;
      CODE_AMP:  seq = SEQ_AMP;
      default:   seq = {lit, 40'h0};
    endcase
    shifted = seq << {pos, 3'b000};
    return shifted[47:40];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hse_front.sv =====
`default_nettype none
module hse_front #(
  parameter int LENGTH_BITS = hse_pkg::LENGTH_BITS_DEFAULT
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               out_capacity_we,
  input  wire  [15:0]       out_capacity,
  input  wire               push,
  input  wire  [7:0]        data_byte,
  input  wire               has_byte,
  input  wire               end_of_string,
  input  wire               q_full,
  output logic              job_we,
  output hse_pkg::job_t     job
);

  localparam int CMP_W = hse_pkg::MAX_LEN_BITS + 1;

  logic [15:0]            capacity;
  logic [LENGTH_BITS-1:0] count;
  logic [LENGTH_BITS-1:0] count_next;
  logic                   stopped;
  logic                   stopped_next;
  logic                   seen;
  logic                   seen_next;
  logic                   accept;
  logic                   fits;
  hse_pkg::code_t         code;
  logic [2:0]             len;

  assign accept = push && !q_full;
  assign code   = hse_pkg::esc_code(data_byte);
  assign len    = hse_pkg::esc_len(code);
  assign fits   = (CMP_W'(count) + CMP_W'(len)) < CMP_W'(capacity);

  // Classify the item and update the string state
  always_comb begin
    count_next   = count;
    stopped_next = stopped;
    seen_next    = seen;
    job          = '0;
    job.code     = hse_pkg::CODE_LIT;
    if (accept) begin
      if (has_byte) begin
        seen_next = 1'b1;
        if (!stopped) begin
          if (fits) begin
            count_next    = count + LENGTH_BITS'(len);
            job.has_bytes = 1'b1;
            job.code      = code;
            job.lit       = data_byte;
          end else begin
            stopped_next = 1'b1;
          end
        end
      end
      if (end_of_string) begin
        job.has_term   = 1'b1;
        job.term_store = (capacity != 16'd0) && seen_next;
        job.term_trunc = stopped_next;
        count_next     = '0;
        stopped_next   = 1'b0;
        seen_next      = 1'b0;
      end
    end
  end

  assign job_we = accept && (job.has_bytes || job.has_term);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
      count    <= '0;
      stopped  <= 1'b0;
      seen     <= 1'b0;
    end else begin
      if (out_capacity_we) begin
        capacity <= out_capacity;
      end
      count   <= count_next;
      stopped <= stopped_next;
      seen    <= seen_next;
    end
  end

  // A string stops only after it has carried a byte
  a_stop_seen: assert property (@(posedge clk) disable iff (rst) stopped |-> seen)
    else $error("stopped without any byte seen");

endmodule
`default_nettype wire

// ===== rtl/hse_queue.sv =====
`default_nettype none
module hse_queue (
  input  wire            clk,
  input  wire            rst,
  input  wire            wr_en,
  input  hse_pkg::job_t  wr_job,
  output logic           full,
  input  wire            rd_en,
  output logic           head_valid,
  output hse_pkg::job_t  head
);

  localparam int DEPTH = hse_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hse_pkg::job_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             do_wr;
  logic             do_rd;

  assign full       = (cnt == CNT_W'(DEPTH));
  assign head_valid = (cnt != '0);
  assign head       = mem[rd_ptr];
  assign do_wr      = wr_en && !full;
  assign do_rd      = rd_en && head_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      cnt <= cnt + CNT_W'(do_wr) - CNT_W'(do_rd);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("job queue fill level beyond depth");

endmodule
`default_nettype wire

// ===== rtl/hse_back.sv =====
`default_nettype none
module hse_back #(
  parameter int LENGTH_BITS = hse_pkg::LENGTH_BITS_DEFAULT
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            head_valid,
  input  hse_pkg::job_t  head,
  output logic           head_pop,
  output logic           empty,
  input  wire            pop,
  output logic [7:0]     out_byte,
  output logic           is_terminator,
  output logic           store_it,
  output logic [15:0]    total_length,
  output logic           truncated,
  output logic           run_last
);

  logic                   out_valid;
  logic [2:0]             pos;
  logic                   in_term;
  logic [LENGTH_BITS-1:0] count;
  logic [LENGTH_BITS-1:0] count_inc;
  logic [31:0]            count_wide;
  logic [31:0]            inc_wide;
  logic                   advance;
  logic                   do_bytes;
  logic                   last_byte;
  logic [2:0]             len;

  assign empty      = !out_valid;
  assign advance    = head_valid && (!out_valid || pop);
  assign do_bytes   = head.has_bytes && !in_term;
  assign len        = hse_pkg::esc_len(head.code);
  assign last_byte  = (pos == len - 3'd1);
  assign count_inc  = count + LENGTH_BITS'(1);
  assign count_wide = 32'(count);
  assign inc_wide   = 32'(count_inc);
  assign head_pop   = advance && (do_bytes ? (last_byte && !head.has_term) : 1'b1);

  // Serializer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
      in_term   <= 1'b0;
      count     <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        if (do_bytes) begin
          count <= count_inc;
          if (last_byte) begin
            pos     <= '0;
            in_term <= head.has_term;
          end else begin
            pos <= pos + 3'd1;
          end
        end else begin
          count   <= '0;
          in_term <= 1'b0;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      if (do_bytes) begin
        out_byte      <= hse_pkg::esc_char(head.code, pos, head.lit);
        is_terminator <= 1'b0;
        store_it      <= 1'b1;
        total_length  <= inc_wide[15:0];
        truncated     <= 1'b0;
        run_last      <= last_byte && !head.has_term;
      end else begin
        out_byte      <= 8'h00;
        is_terminator <= 1'b1;
        store_it      <= head.term_store;
        total_length  <= count_wide[15:0];
        truncated     <= head.term_trunc;
        run_last      <= 1'b1;
      end
    end
  end

  a_term_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_terminator) |-> run_last)
    else $error("terminator not marked as last result");

  a_byte_stored: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_terminator) |-> (store_it && !truncated))
    else $error("data byte with bad store or truncated flag");

  a_term_phase: assert property (@(posedge clk) disable iff (rst)
    in_term |-> (head_valid && head.has_term))
    else $error("terminator phase without a terminating job");

endmodule
`default_nettype wire

// ===== rtl/html_special_char_escaper.sv =====
// HTML special-character escaper.
// Input queue side: present data_byte, has_byte and end_of_string with push;
// the item transfers on a clock edge with push high and full low. Bytes
// < > " ' & expand to &lt; &gt; &quot; &#039; &amp;, others pass through.
// Result queue side: while empty is low the oldest result is on the ports;
// it transfers on a clock edge with pop high. An end item adds a terminator
// result carrying the final length; run_last marks each item's last result.
// Config: out_capacity is written when out_capacity_we is high; the user must
// do so only while idle, as the block does not enforce it. The job queue is
// written at an item's transfer edge; its first result enters the output
// register once its job heads the queue and that register is free or popped.
// Throughput: the back-end serializer emits one result per cycle while pop
// keeps the output register free; a plain byte gives one result, an escape 4
// to 6, a terminator one more. A 4-entry job queue lets the front keep taking
// items during expansions. Reset clears the string state, the job queue, the
// output register's valid flag and out_capacity (to 0).
// When pop stays low the output register holds, the job queue fills and
// full rises; nothing is dropped.
`default_nettype none
module html_special_char_escaper #(
  parameter int LENGTH_BITS = hse_pkg::LENGTH_BITS_DEFAULT
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         out_capacity_we,
  input  wire  [15:0] out_capacity,
  input  wire         push,
  output logic        full,
  input  wire  [7:0]  data_byte,
  input  wire         has_byte,
  input  wire         end_of_string,
  output logic        empty,
  input  wire         pop,
  output logic [7:0]  out_byte,
  output logic        is_terminator,
  output logic        store_it,
  output logic [15:0] total_length,
  output logic        truncated,
  output logic        run_last
);

  logic          job_we;
  hse_pkg::job_t job;
  logic          head_valid;
  hse_pkg::job_t head;
  logic          head_pop;

  // Front: classify and fit-check each item
  hse_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk             (clk),
    .rst             (rst),
    .out_capacity_we (out_capacity_we),
    .out_capacity    (out_capacity),
    .push            (push),
    .data_byte       (data_byte),
    .has_byte        (has_byte),
    .end_of_string   (end_of_string),
    .q_full          (full),
    .job_we          (job_we),
    .job             (job)
  );

  // Job queue between the two sides
  hse_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (job_we),
    .wr_job     (job),
    .full       (full),
    .rd_en      (head_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: serialize expansions and terminators
  hse_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .head_pop      (head_pop),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .is_terminator (is_terminator),
    .store_it      (store_it),
    .total_length  (total_length),
    .truncated     (truncated),
    .run_last      (run_last)
  );

endmodule
`default_nettype wire
